// File: hw/rtl/irbp_pkg.sv
// ----------------------------------------------------------------------------
// irbp_pkg
// Shared constants, request modes and status codes of the block pool.
// ----------------------------------------------------------------------------
`default_nettype none
package irbp_pkg;

  localparam int POOL_SIZE     = 256;
  localparam int BLOCK_W       = 8;
  localparam int DEPTH_W       = 9;
  localparam int THREADS       = 8;
  localparam int THREAD_W      = 3;
  localparam int EPOCH_W       = 32;
  localparam int COUNT_W       = 32;
  localparam int PERIOD_W      = 16;
  localparam int RECYCLE_LIMIT = 64;

  localparam logic [EPOCH_W-1:0] EPOCH_ONES = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX  = EPOCH_ONES - EPOCH_W'(1);

  localparam logic [2:0] MODE_ALLOC = 3'd0;
  localparam logic [2:0] MODE_RETIRE = 3'd1;
  localparam logic [2:0] MODE_START = 3'd2;
  localparam logic [2:0] MODE_END = 3'd3;
  localparam logic [2:0] MODE_READ = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  localparam logic CFG_EPOCH_PERIOD = 1'b0;
  localparam logic CFG_RECYCLE_PERIOD = 1'b1;

endpackage
`default_nettype wire

// File: hw/rtl/irbp_ram.sv
// ----------------------------------------------------------------------------
// irbp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module irbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/irbp_rem_unit.sv
// ----------------------------------------------------------------------------
// irbp_rem_unit
// Bit-serial restoring remainder of a request count by a period, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module irbp_rem_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            go,
  input  wire logic [irbp_pkg::COUNT_W-1:0]    dividend,
  input  wire logic [irbp_pkg::PERIOD_W-1:0]   divisor,
  output logic                                 done,
  output logic      [irbp_pkg::PERIOD_W-1:0]   rem
);
  import irbp_pkg::*;

  localparam int CNT_W = $clog2(COUNT_W + 1);

  logic [COUNT_W-1:0]  shreg;
  logic [CNT_W-1:0]    bits_left;
  logic                running;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   diff;

  assign trial = {rem, shreg[COUNT_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      done      <= 1'b0;
      bits_left <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running   <= 1'b1;
        bits_left <= CNT_W'(COUNT_W);
      end else if (running) begin
        bits_left <= bits_left - CNT_W'(1);
        if (bits_left == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (running) begin
      shreg <= {shreg[COUNT_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[PERIOD_W-1:0];
      end else begin
        rem <= trial[PERIOD_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/interval_reclaim_block_pool.sv
// ----------------------------------------------------------------------------
// interval_reclaim_block_pool
// Block index pool with interval-based reclamation of retired blocks.
// ----------------------------------------------------------------------------
// One request at a time: busy is high from acceptance until the result strobe
// done, which is high for one cycle and cannot be held off. Start, end and
// unknown modes pass through dispatch to done; read adds a wait state. Allocate
// and retire run the count through a bit-serial remainder unit. A recycle pass
// pops each retired block, fetches its stamps, compares them with each thread's
// reservation in turn (up to 8 threads), and pushes kept blocks back. The free
// stack needs no clearing pass after reset.
`default_nettype none
module interval_reclaim_block_pool #(
  parameter int RECYCLE_LIMIT = irbp_pkg::RECYCLE_LIMIT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [irbp_pkg::PERIOD_W-1:0]  cfg_data,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [2:0]                     mode,
  input  wire logic [irbp_pkg::THREAD_W-1:0]  thread,
  input  wire logic [irbp_pkg::BLOCK_W-1:0]   block_index,
  output logic                                done,
  output logic      [1:0]                     status,
  output logic      [irbp_pkg::BLOCK_W-1:0]   granted_block,
  output logic      [irbp_pkg::EPOCH_W-1:0]   epoch_now
);
  import irbp_pkg::*;

  localparam int KW = $clog2(RECYCLE_LIMIT + 1);
  localparam int KA = (RECYCLE_LIMIT > 1) ? $clog2(RECYCLE_LIMIT) : 1;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_DISPATCH  = 14'b00000000000010,
    S_CNT       = 14'b00000000000100,
    S_DIV       = 14'b00000000001000,
    S_ALLOC     = 14'b00000000010000,
    S_RET_FIN   = 14'b00000000100000,
    S_READ_WAIT = 14'b00000001000000,
    S_DONE      = 14'b00000010000000,
    S_REC_POP   = 14'b00000100000000,
    S_REC_BLK   = 14'b00001000000000,
    S_REC_STAMP = 14'b00010000000000,
    S_REC_SCAN  = 14'b00100000000000,
    S_REC_BACK  = 14'b01000000000000,
    S_REC_PUSH  = 14'b10000000000000
  } state_t;

  state_t state;

  logic [PERIOD_W-1:0] epoch_period;
  logic [PERIOD_W-1:0] recycle_period;

  logic [2:0]          mode_q;
  logic [THREAD_W-1:0] th_q;
  logic [BLOCK_W-1:0]  blk_q;
  logic [EPOCH_W-1:0]  epoch;
  logic [COUNT_W-1:0]  counts   [THREADS];
  logic [EPOCH_W-1:0]  res_low  [THREADS];
  logic [EPOCH_W-1:0]  res_high [THREADS];
  logic [DEPTH_W-1:0]  fd;
  logic [DEPTH_W-1:0]  rd;
  logic [DEPTH_W-1:0]  spare;
  logic [DEPTH_W-1:0]  low_water;
  logic [KW-1:0]       kept_n;
  logic [KW-1:0]       back_i;
  logic [THREAD_W-1:0] scan_t;
  logic [BLOCK_W-1:0]  cur_blk;
  logic [EPOCH_W-1:0]  born_q;
  logic [EPOCH_W-1:0]  ret_q;

  logic [DEPTH_W-1:0]  fd_dec;
  logic [DEPTH_W-1:0]  rd_dec;
  logic                hit;
  logic                ret_ok;
  logic [COUNT_W-1:0]  cnt_new;
  logic [PERIOD_W-1:0] period;
  logic                div_done;
  logic [PERIOD_W-1:0] div_rem;
  logic                period_hit;
  logic [BLOCK_W-1:0]  granted_w;

  logic                free_we;
  logic [BLOCK_W-1:0]  free_rdata;
  logic                retd_we;
  logic [BLOCK_W-1:0]  retd_wdata;
  logic [BLOCK_W-1:0]  retd_rdata;
  logic                born_we;
  logic [BLOCK_W-1:0]  born_raddr;
  logic [EPOCH_W-1:0]  born_rdata;
  logic                rete_we;
  logic [EPOCH_W-1:0]  rete_rdata;
  logic                kept_we;
  logic [BLOCK_W-1:0]  kept_rdata;

  assign fd_dec     = fd - DEPTH_W'(1);
  assign rd_dec     = rd - DEPTH_W'(1);
  assign hit        = (born_q <= res_high[scan_t]) && (ret_q >= res_low[scan_t]);
  assign ret_ok     = (spare != '0) && (rd < DEPTH_W'(POOL_SIZE));
  assign cnt_new    = counts[th_q] + COUNT_W'(1);
  assign period     = (mode_q == MODE_ALLOC) ? epoch_period : recycle_period;
  assign period_hit = (period != '0) && (div_rem == '0);
  assign granted_w  = (fd_dec < low_water) ? fd_dec[BLOCK_W-1:0] : free_rdata;

  assign free_we    = (state == S_REC_SCAN) && !hit && (scan_t == THREAD_W'(THREADS - 1));
  assign retd_we    = ((state == S_RET_FIN) && ret_ok) ||
                      ((state == S_REC_PUSH) && (rd < DEPTH_W'(POOL_SIZE)));
  assign retd_wdata = (state == S_REC_PUSH) ? kept_rdata : blk_q;
  assign born_we    = (state == S_ALLOC);
  assign born_raddr = (state == S_REC_BLK) ? retd_rdata : blk_q;
  assign rete_we    = (state == S_RET_FIN) && ret_ok;
  assign kept_we    = (state == S_REC_SCAN) && hit;

  assign busy      = (state != S_IDLE);
  assign epoch_now = epoch;

  irbp_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .go       (state == S_CNT),
    .dividend (cnt_new),
    .divisor  (period),
    .done     (div_done),
    .rem      (div_rem)
  );

  irbp_ram #(.WIDTH(BLOCK_W), .DEPTH(POOL_SIZE)) u_free_stack (
    .clk   (clk),
    .we    (free_we),
    .waddr (fd[BLOCK_W-1:0]),
    .wdata (cur_blk),
    .raddr (fd_dec[BLOCK_W-1:0]),
    .rdata (free_rdata)
  );

  irbp_ram #(.WIDTH(BLOCK_W), .DEPTH(POOL_SIZE)) u_retired_stack (
    .clk   (clk),
    .we    (retd_we),
    .waddr (rd[BLOCK_W-1:0]),
    .wdata (retd_wdata),
    .raddr (rd_dec[BLOCK_W-1:0]),
    .rdata (retd_rdata)
  );

  irbp_ram #(.WIDTH(EPOCH_W), .DEPTH(POOL_SIZE)) u_born (
    .clk   (clk),
    .we    (born_we),
    .waddr (granted_w),
    .wdata (epoch),
    .raddr (born_raddr),
    .rdata (born_rdata)
  );

  irbp_ram #(.WIDTH(EPOCH_W), .DEPTH(POOL_SIZE)) u_retire (
    .clk   (clk),
    .we    (rete_we),
    .waddr (blk_q),
    .wdata (epoch),
    .raddr (retd_rdata),
    .rdata (rete_rdata)
  );

  irbp_ram #(.WIDTH(BLOCK_W), .DEPTH(RECYCLE_LIMIT), .ADDR_W(KA)) u_kept (
    .clk   (clk),
    .we    (kept_we),
    .waddr (kept_n[KA-1:0]),
    .wdata (cur_blk),
    .raddr (back_i[KA-1:0]),
    .rdata (kept_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_period   <= PERIOD_W'(16);
      recycle_period <= PERIOD_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EPOCH_PERIOD:   epoch_period <= cfg_data;
        CFG_RECYCLE_PERIOD: recycle_period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      epoch     <= '0;
      fd        <= DEPTH_W'(POOL_SIZE);
      low_water <= DEPTH_W'(POOL_SIZE);
      rd        <= '0;
      spare     <= '0;
      kept_n    <= '0;
      back_i    <= '0;
      scan_t    <= '0;
      for (int i = 0; i < THREADS; i++) begin
        counts[i]   <= '0;
        res_low[i]  <= EPOCH_ONES;
        res_high[i] <= EPOCH_ONES;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            mode_q   <= mode;
            th_q     <= thread;
            blk_q    <= block_index;
            status   <= ST_OK;
            granted_block <= block_index;
            state    <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          kept_n <= '0;
          back_i <= '0;
          case (mode_q)
            MODE_ALLOC: state <= (fd == '0) ? S_REC_POP : S_CNT;
            MODE_RETIRE: state <= S_CNT;
            MODE_START: begin
              res_low[th_q]  <= epoch;
              res_high[th_q] <= epoch;
              state <= S_DONE;
            end
            MODE_END: begin
              res_low[th_q]  <= EPOCH_ONES;
              res_high[th_q] <= EPOCH_ONES;
              state <= S_DONE;
            end
            MODE_READ: state <= S_READ_WAIT;
            default: state <= S_DONE;
          endcase
        end
        S_CNT: begin
          counts[th_q] <= cnt_new;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (mode_q == MODE_ALLOC) begin
              if (period_hit && (epoch < EPOCH_MAX)) begin
                epoch <= epoch + EPOCH_W'(1);
              end
              if (fd == '0) begin
                status <= ST_NO_FREE;
                granted_block <= '0;
                state <= S_DONE;
              end else begin
                state <= S_ALLOC;
              end
            end else begin
              kept_n <= '0;
              back_i <= '0;
              state <= period_hit ? S_REC_POP : S_RET_FIN;
            end
          end
        end
        S_ALLOC: begin
          granted_block <= granted_w;
          fd <= fd_dec;
          if (fd_dec < low_water) begin
            low_water <= fd_dec;
          end
          if (spare < DEPTH_W'(POOL_SIZE)) begin
            spare <= spare + DEPTH_W'(1);
          end
          state <= S_DONE;
        end
        S_RET_FIN: begin
          if (ret_ok) begin
            spare <= spare - DEPTH_W'(1);
            rd    <= rd + DEPTH_W'(1);
          end else begin
            status <= ST_DROPPED;
          end
          state <= S_DONE;
        end
        S_READ_WAIT: begin
          res_high[th_q] <= born_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_REC_POP: begin
          if ((rd == '0) || (kept_n == KW'(RECYCLE_LIMIT))) begin
            state <= S_REC_BACK;
          end else begin
            rd    <= rd_dec;
            state <= S_REC_BLK;
          end
        end
        S_REC_BLK: begin
          cur_blk <= retd_rdata;
          state   <= S_REC_STAMP;
        end
        S_REC_STAMP: begin
          born_q <= born_rdata;
          ret_q  <= rete_rdata;
          scan_t <= '0;
          state  <= S_REC_SCAN;
        end
        S_REC_SCAN: begin
          if (hit) begin
            kept_n <= kept_n + KW'(1);
            state  <= S_REC_POP;
          end else if (scan_t == THREAD_W'(THREADS - 1)) begin
            fd    <= fd + DEPTH_W'(1);
            state <= S_REC_POP;
          end else begin
            scan_t <= scan_t + THREAD_W'(1);
          end
        end
        S_REC_BACK: begin
          if (back_i == kept_n) begin
            state <= (mode_q == MODE_ALLOC) ? S_CNT : S_RET_FIN;
          end else begin
            state <= S_REC_PUSH;
          end
        end
        S_REC_PUSH: begin
          if (rd < DEPTH_W'(POOL_SIZE)) begin
            rd <= rd + DEPTH_W'(1);
          end
          back_i <= back_i + KW'(1);
          state  <= S_REC_BACK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // blocks are never lost or duplicated across the three counts between requests
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |->
    (({1'b0, fd} + {1'b0, rd} + {1'b0, spare}) == (DEPTH_W + 1)'(POOL_SIZE)))
    else $error("pool accounting broken");

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy && !done))
    else $error("request not taken up");

  assert property (@(posedge clk) disable iff (rst) done |-> (status != 2'd3))
    else $error("bad status code");

  assert property (@(posedge clk) disable iff (rst) kept_n <= KW'(RECYCLE_LIMIT))
    else $error("kept buffer overrun");

endmodule
`default_nettype wire
